>>> hdl/gdd_pkg.sv
// Shared widths, calendar constants and the month offset table for the
// Gregorian day difference block. No dependencies.
package gdd_pkg;

   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int COUNT_W = 22;

   // Day number of one date, years 0 .. 16383 included
   localparam int DNUM_W  = 23;
   // Day of year, at most 366
   localparam int DOY_W   = 9;
   // Sum of the leap-day corrections of the whole years
   localparam int QSUM_W  = 13;

   localparam int DAYS_PER_YEAR = 365;
   localparam int DAYS_LEAP_YEAR = 366;
   localparam int CENTURY       = 100;
   localparam int QUAD_CENTURY  = 400;

   // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for every x below 2^15
   localparam int RECIP_100   = 5243;
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 19;
   localparam int PROD_W      = YEAR_W + 1 + RECIP_W;
   localparam int QCENT_W     = PROD_W - RECIP_SHIFT;

   localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
   localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
   localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

   // Days before the first of the month; month 0 reads as January and
   // months past December read as December
   function automatic logic [DOY_W-1:0] days_before_month(input logic [MONTH_W-1:0] month);
      logic [DOY_W-1:0] offset;
      case (month)
         4'd0, 4'd1: offset = 9'd0;
         4'd2:       offset = 9'd31;
         4'd3:       offset = 9'd59;
         4'd4:       offset = 9'd90;
         4'd5:       offset = 9'd120;
         4'd6:       offset = 9'd151;
         4'd7:       offset = 9'd181;
         4'd8:       offset = 9'd212;
         4'd9:       offset = 9'd243;
         4'd10:      offset = 9'd273;
         4'd11:      offset = 9'd304;
         default:    offset = 9'd334;
      endcase
      return offset;
   endfunction

endpackage

>>> hdl/gdd_if.sv
// Valid/ready channel interfaces for the date pair transaction and the
// day count transaction. Depends on gdd_pkg.
interface gdd_req_if import gdd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [YEAR_W-1:0]  first_year;
   logic [MONTH_W-1:0] first_month;
   logic [DAY_W-1:0]   first_day;
   logic [YEAR_W-1:0]  second_year;
   logic [MONTH_W-1:0] second_month;
   logic [DAY_W-1:0]   second_day;

   modport source (
      output valid, first_year, first_month, first_day,
      output second_year, second_month, second_day,
      input  ready
   );
   modport sink (
      input  valid, first_year, first_month, first_day,
      input  second_year, second_month, second_day,
      output ready
   );
endinterface

interface gdd_rsp_if import gdd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] day_count;
   logic               first_was_later;

   modport source (
      output valid, day_count, first_was_later,
      input  ready
   );
   modport sink (
      input  valid, day_count, first_was_later,
      output ready
   );
endinterface

>>> hdl/gdd_day_number.sv
// Three-stage pipeline that turns one year/month/day into its day number
// counted from year 0. Depends on gdd_pkg.
module gdd_day_number import gdd_pkg::*; (
   input  logic               clock,
   input  logic               advance,
   input  logic [YEAR_W-1:0]  year,
   input  logic [MONTH_W-1:0] month,
   input  logic [DAY_W-1:0]   day,
   output logic [DNUM_W-1:0]  day_num
);

   // Stage 1 registers
   logic [YEAR_W-1:0]  year1_ff;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [DOY_W-1:0]   mdoy_ff, mdoy_in;
   logic               after_feb1_ff, after_feb1_in;

   // Stage 2 registers
   logic [DNUM_W-1:0]  yday_ff, yday_in;
   logic [QSUM_W-1:0]  qsum_ff, qsum_in;
   logic [DOY_W-1:0]   doy_ff, doy_in;

   // Stage 3 register
   logic [DNUM_W-1:0]  dnum_ff, dnum_in;

   logic [QCENT_W-1:0] q100;
   logic [QCENT_W-1:0] q400;
   logic [QSUM_W-1:0]  q4;
   logic               century;
   logic               leap;

   // Stage 1: ceil(year / 100) by reciprocal product, month offset plus day
   always_comb begin
      prod_in = PROD_W'(({1'b0, year} + (YEAR_W + 1)'(CENTURY - 1)))
              * PROD_W'(RECIP_100);
      mdoy_in = days_before_month(month) + DOY_W'(day);
      after_feb1_in = (month > MONTH_FEB);
   end

   // Stage 2: whole-year days and leap correction of this year
   always_comb begin
      q100 = prod_ff[PROD_W-1:RECIP_SHIFT];
      q400 = (q100 + QCENT_W'(3)) >> 2;
      q4 = QSUM_W'(({1'b0, year1_ff} + (YEAR_W + 1)'(3)) >> 2);
      century = ((YEAR_W + 1)'(q100) * (YEAR_W + 1)'(CENTURY)) == {1'b0, year1_ff};
      leap = (year1_ff[1:0] == 2'd0) && (!century || (year1_ff[3:0] == 4'd0));
      yday_in = DNUM_W'(year1_ff) * DNUM_W'(DAYS_PER_YEAR);
      qsum_in = q4 - QSUM_W'(q100) + QSUM_W'(q400);
      doy_in = mdoy_ff + DOY_W'(leap && after_feb1_ff);
   end

   // Stage 3: add the parts
   always_comb begin
      dnum_in = yday_ff + DNUM_W'(qsum_ff) + DNUM_W'(doy_ff);
   end

   // Advance all stages together; hold while the output is stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         year1_ff      <= year;
         prod_ff       <= prod_in;
         mdoy_ff       <= mdoy_in;
         after_feb1_ff <= after_feb1_in;
         yday_ff       <= yday_in;
         qsum_ff       <= qsum_in;
         doy_ff        <= doy_in;
         dnum_ff       <= dnum_in;
      end
   end

   assign day_num = dnum_ff;

endmodule

>>> hdl/gdd_compare.sv
// Final stage: absolute difference of two day numbers, order flag and
// saturation to the count width. Depends on gdd_pkg.
module gdd_compare import gdd_pkg::*; (
   input  logic               clock,
   input  logic               advance,
   input  logic [DNUM_W-1:0]  first_num,
   input  logic [DNUM_W-1:0]  second_num,
   output logic [COUNT_W-1:0] day_count,
   output logic               first_was_later
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               later_ff, later_in;
   logic [DNUM_W-1:0]  diff;

   // Subtract the smaller from the larger and clamp at the count limit
   always_comb begin
      later_in = (first_num > second_num);
      diff = later_in ? (first_num - second_num) : (second_num - first_num);
      count_in = (diff[DNUM_W-1:COUNT_W] != '0) ? '1 : diff[COUNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         count_ff <= count_in;
         later_ff <= later_in;
      end
   end

   assign day_count = count_ff;
   assign first_was_later = later_ff;

endmodule

>>> hdl/gregorian_day_difference_top.sv
// Top level of the Gregorian day difference block: two day number pipelines
// and the compare stage. Depends on gdd_pkg, gdd_if, gdd_day_number, gdd_compare.
//
// Usage:
//   req_chan carries one date pair per transaction; rsp_chan returns the
//   absolute day count between the two dates and a flag that is set when the
//   first date lies after the second. Exactly one response per request, in
//   order. Both channels accept a transaction on a rising clock edge where
//   valid and ready are both high.
//   There are four register stages. Three stages build each day number
//   (reciprocal multiply for the century count, year length product, final
//   sum) and one stage forms the difference. Throughput is one transaction
//   per cycle while the response is not held.
//   All stages advance together. When the response is held (rsp_chan.ready
//   low with a valid response waiting), the whole pipeline holds and
//   req_chan.ready drops in the same cycle; nothing is lost or repeated.
//   Synchronous reset clears all valid bits and holds req_chan.ready low
//   while it is high; no response is pending after reset and no clearing
//   pass is needed.
module gregorian_day_difference_top import gdd_pkg::*; (
   input  logic clock,
   input  logic reset,
   gdd_req_if.sink   req_chan,
   gdd_rsp_if.source rsp_chan
);

   localparam int DEPTH = 4;

   logic [DEPTH-1:0]  valid_ff, valid_in;
   logic              advance;
   logic [DNUM_W-1:0] first_num;
   logic [DNUM_W-1:0] second_num;

   // Move when the last stage is empty or its transaction is being taken
   assign advance = !valid_ff[DEPTH-1] || rsp_chan.ready;
   assign req_chan.ready = advance && !reset;

   always_comb begin
      valid_in = advance ? {valid_ff[DEPTH-2:0], req_chan.valid} : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   gdd_day_number u_first (
      .clock   (clock),
      .advance (advance),
      .year    (req_chan.first_year),
      .month   (req_chan.first_month),
      .day     (req_chan.first_day),
      .day_num (first_num)
   );

   gdd_day_number u_second (
      .clock   (clock),
      .advance (advance),
      .year    (req_chan.second_year),
      .month   (req_chan.second_month),
      .day     (req_chan.second_day),
      .day_num (second_num)
   );

   gdd_compare u_compare (
      .clock           (clock),
      .advance         (advance),
      .first_num       (first_num),
      .second_num      (second_num),
      .day_count       (rsp_chan.day_count),
      .first_was_later (rsp_chan.first_was_later)
   );

   assign rsp_chan.valid = valid_ff[DEPTH-1];

endmodule
